[rtl/ptbt_pkg.sv]
package ptbt_pkg;

  // Field formats
  localparam int COORD_W = 32;            // signed Q16.16 coordinate
  localparam int TFB     = 16;            // fraction bits of t
  localparam int THR_W   = 16;            // degenerate threshold width
  localparam int ACT_W   = 3;

  // Solver widths
  localparam int SW      = COORD_W + 5;   // signed width of curve coefficients
  localparam int DW      = SW - 1;        // unsigned divider operand width
  localparam int NORM_SH = 30;            // normalized magnitude limit is 2^30
  localparam int NW      = NORM_SH + 1;   // signed width after normalization
  localparam int SQ_W    = 2 * (NW + 1);  // discriminant / square root width
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int RT_W    = SQ_W / 2;      // square root result width
  localparam int LP_W    = COORD_W + TFB + 2;

  localparam int DIV_CNT_W = $clog2(TFB);
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);
  localparam int CUBIC_STEPS = 6;
  localparam int QUAD_STEPS  = 3;
  localparam int STEP_W = $clog2(CUBIC_STEPS);

  // Action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_MOVE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LINE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_QUAD  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CUBIC = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLOSE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SW-1:0]      sw_t;

  typedef enum logic [2:0] {
    K_MOVE, K_LINE, K_QUAD, K_CUBIC, K_CLOSE, K_CLEAR, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    coord_t ex;
    coord_t ey;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } cmd_t;

  typedef struct packed {
    logic   known;
    coord_t lo_x;
    coord_t lo_y;
    coord_t hi_x;
    coord_t hi_y;
  } box_t;

  typedef struct packed {
    box_t box;
    logic nonempty;
    logic status;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INC_START, S_INC_END, S_SETUP, S_NORM, S_MUL1, S_MUL2, S_DISC,
    S_SQRT, S_ROOT, S_DIV_CHK, S_DIV, S_EVAL_LOAD, S_LERP_A, S_LERP_B,
    S_INC_ROOT, S_NEXT, S_FINISH, S_EMIT
  } st_t;

  // Magnitude of a signed coefficient
  function automatic logic [SW-1:0] mag(sw_t v);
    return v[SW-1] ? (~v + 1'b1) : v;
  endfunction

  // Grow the box by one point
  function automatic box_t box_add(box_t b, coord_t x, coord_t y);
    box_t n;
    n = b;
    if (!b.known) begin
      n.known = 1'b1;
      n.lo_x  = x;
      n.hi_x  = x;
      n.lo_y  = y;
      n.hi_y  = y;
    end else begin
      if ($signed(x) < $signed(b.lo_x)) n.lo_x = x;
      if ($signed(x) > $signed(b.hi_x)) n.hi_x = x;
      if ($signed(y) < $signed(b.lo_y)) n.lo_y = y;
      if ($signed(y) > $signed(b.hi_y)) n.hi_y = y;
    end
    return n;
  endfunction

  // de Casteljau schedule: point pair (i, i+1) interpolated into i
  function automatic logic [1:0] step_index(logic cubic, logic [STEP_W-1:0] step);
    logic [1:0] idx;
    idx = 2'd0;
    if (cubic) begin
      case (step)
        3'd1: idx = 2'd1;
        3'd2: idx = 2'd2;
        3'd4: idx = 2'd1;
        default: idx = 2'd0;
      endcase
    end else begin
      case (step)
        3'd1: idx = 2'd1;
        default: idx = 2'd0;
      endcase
    end
    return idx;
  endfunction

endpackage

[rtl/ptbt_if.sv]
// Command channel
interface ptbt_in_if import ptbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  coord_t             end_x;
  coord_t             end_y;
  coord_t             ctrl_a_x;
  coord_t             ctrl_a_y;
  coord_t             ctrl_b_x;
  coord_t             ctrl_b_y;

  modport source (output valid, action, end_x, end_y, ctrl_a_x, ctrl_a_y,
                  ctrl_b_x, ctrl_b_y, input ready);
  modport sink   (input valid, action, end_x, end_y, ctrl_a_x, ctrl_a_y,
                  ctrl_b_x, ctrl_b_y, output ready);
endinterface

// Result channel
interface ptbt_out_if import ptbt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t min_x;
  coord_t min_y;
  coord_t max_x;
  coord_t max_y;
  logic   bounds_valid;
  logic   path_nonempty;
  logic   status;

  modport source (output valid, min_x, min_y, max_x, max_y, bounds_valid,
                  path_nonempty, status, input ready);
  modport sink   (input valid, min_x, min_y, max_x, max_y, bounds_valid,
                  path_nonempty, status, output ready);
endinterface

[rtl/ptbt_front.sv]
module ptbt_front import ptbt_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  ptbt_in_if.sink      in_beat,
  output logic         cmd_valid,
  output cmd_t         cmd,
  input  logic         cmd_ready
);

  localparam int PTR_W = $clog2(DEPTH);

  cmd_t               ent_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  kind_t              kind;
  cmd_t               in_cmd;
  logic               push, pop;

  // Classify the action code
  always_comb begin
    case (in_beat.action)
      ACT_MOVE:  kind = K_MOVE;
      ACT_LINE:  kind = K_LINE;
      ACT_QUAD:  kind = K_QUAD;
      ACT_CUBIC: kind = K_CUBIC;
      ACT_CLOSE: kind = K_CLOSE;
      ACT_CLEAR: kind = K_CLEAR;
      default:   kind = K_NOP;
    endcase
  end

  assign in_cmd = '{kind: kind, ex: in_beat.end_x, ey: in_beat.end_y,
                    ax: in_beat.ctrl_a_x, ay: in_beat.ctrl_a_y,
                    bx: in_beat.ctrl_b_x, by: in_beat.ctrl_b_y};

  // Command queue
  assign in_beat.ready = (cnt_r != (PTR_W + 1)'(DEPTH));
  assign push      = in_beat.valid && in_beat.ready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= in_cmd;
  end

endmodule

[rtl/ptbt_back.sv]
module ptbt_back import ptbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [THR_W-1:0]  thr,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_ready,
  ptbt_out_if.source        out_beat
);

  localparam logic [SW-1:0]   NORM_LIM = SW'(1) << NORM_SH;
  localparam logic [SQ_W-1:0] SQ_BIT0  = SQ_W'(1) << (SQ_W - 2);

  // Control state
  st_t    state_r, state_nxt;
  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic   active_r, active_nxt, seg_r, seg_nxt;
  box_t   box_r, box_nxt;
  logic   ov_r, ov_nxt;

  // Working registers
  cmd_t                 cmd_r, cmd_nxt;
  logic                 status_r, status_nxt;
  logic                 axis_r, axis_nxt, eaxis_r, eaxis_nxt;
  logic                 pair_r, pair_nxt, rsel_r, rsel_nxt;
  sw_t                  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [SW-1:0]        m_r, m_nxt;
  logic signed [2*NW-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [SQ_W-1:0]      v_r, v_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic [SQ_CNT_W-1:0]  sq_cnt_r, sq_cnt_nxt;
  sw_t                  num_r, num_nxt, den_r, den_nxt;
  logic [DW-1:0]        dd_r, dd_nxt;
  logic [DW:0]          rem_r, rem_nxt;
  logic [TFB-1:0]       t_r, t_nxt;
  logic [DIV_CNT_W-1:0] dv_cnt_r, dv_cnt_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  coord_t               q0_r, q0_nxt, q1_r, q1_nxt, q2_r, q2_nxt, q3_r, q3_nxt;
  logic signed [LP_W-1:0] lp_r, lp_nxt;
  coord_t               px_r, px_nxt, py_r, py_nxt;
  res_t                 ores_r, ores_nxt;

  // Combinational helpers
  logic              is_cubic, last_step;
  logic [SW-1:0]     thr_ext;
  sw_t               s0, s1, s2, s3;
  sw_t               quad_d, quad_n, cub_a, cub_b, cub_c;
  logic [SW-1:0]     ma, mb, mc, mmax;
  sw_t               an_s, bn_s, rt_s;
  logic signed [SQ_W:0] disc;
  logic [SQ_W-1:0]   sq_sum;
  logic [SW-1:0]     dn, dd;
  logic [DW:0]       rem2;
  coord_t            ev_s, ev_a, ev_b, ev_e;
  logic [1:0]        idx;
  coord_t            lo, hi, lres;
  logic signed [COORD_W:0] diff;
  logic signed [LP_W-1:0]  adj, del;

  assign cmd_ready = (state_r == S_IDLE);
  assign is_cubic  = (cmd_r.kind == K_CUBIC);
  assign thr_ext   = {{(SW - THR_W){1'b0}}, thr};

  // Curve points of the axis being solved
  always_comb begin
    s0 = sw_t'(axis_r ? cur_y_r    : cur_x_r);
    s1 = sw_t'(axis_r ? cmd_r.ay   : cmd_r.ax);
    s2 = sw_t'(axis_r ? cmd_r.by   : cmd_r.bx);
    s3 = sw_t'(axis_r ? cmd_r.ey   : cmd_r.ex);
    quad_d = s0 - (s1 <<< 1) + s3;
    quad_n = s0 - s1;
    cub_a  = s3 - s0 + ((s1 - s2) <<< 1) + (s1 - s2);
    cub_b  = (s0 - (s1 <<< 1) + s2) <<< 1;
    cub_c  = s1 - s0;
    ma = mag(cub_a);
    mb = mag(cub_b);
    mc = mag(cub_c);
    mmax = ma;
    if (mb > mmax) mmax = mb;
    if (mc > mmax) mmax = mc;
  end

  // Normalized coefficients and square root
  always_comb begin
    an_s = sw_t'($signed(a_r[NW-1:0]));
    bn_s = sw_t'($signed(b_r[NW-1:0]));
    rt_s = sw_t'({1'b0, rt_r[RT_W-1:0]});
    disc = (SQ_W + 1)'(p1_r) - ((SQ_W + 1)'(p2_r) <<< 2);
    sq_sum = rt_r + bit_r;
    dn = mag(num_r);
    dd = mag(den_r);
    rem2 = {rem_r[DW-1:0], 1'b0};
  end

  // Interpolation operands
  always_comb begin
    ev_s = eaxis_r ? cur_y_r  : cur_x_r;
    ev_a = eaxis_r ? cmd_r.ay : cmd_r.ax;
    ev_b = eaxis_r ? cmd_r.by : cmd_r.bx;
    ev_e = eaxis_r ? cmd_r.ey : cmd_r.ex;
    idx  = step_index(is_cubic, step_r);
    last_step = is_cubic ? (step_r == STEP_W'(CUBIC_STEPS - 1))
                         : (step_r == STEP_W'(QUAD_STEPS - 1));
    case (idx)
      2'd1:    begin lo = q1_r; hi = q2_r; end
      2'd2:    begin lo = q2_r; hi = q3_r; end
      default: begin lo = q0_r; hi = q1_r; end
    endcase
    diff = (COORD_W + 1)'(hi) - (COORD_W + 1)'(lo);
    // truncate toward zero
    adj  = lp_r + $signed({{(LP_W - TFB){1'b0}}, {TFB{lp_r[LP_W-1]}}});
    del  = adj >>> TFB;
    lres = lo + del[COORD_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cur_x_nxt = cur_x_r;   cur_y_nxt = cur_y_r;
    org_x_nxt = org_x_r;   org_y_nxt = org_y_r;
    active_nxt = active_r; seg_nxt = seg_r;
    box_nxt   = box_r;
    ov_nxt    = ov_r;
    cmd_nxt   = cmd_r;     status_nxt = status_r;
    axis_nxt  = axis_r;    eaxis_nxt = eaxis_r;
    pair_nxt  = pair_r;    rsel_nxt = rsel_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; m_nxt = m_r;
    p1_nxt = p1_r; p2_nxt = p2_r;
    v_nxt = v_r; rt_nxt = rt_r; bit_nxt = bit_r; sq_cnt_nxt = sq_cnt_r;
    num_nxt = num_r; den_nxt = den_r;
    dd_nxt = dd_r; rem_nxt = rem_r; t_nxt = t_r; dv_cnt_nxt = dv_cnt_r;
    step_nxt = step_r;
    q0_nxt = q0_r; q1_nxt = q1_r; q2_nxt = q2_r; q3_nxt = q3_r;
    lp_nxt = lp_r;
    px_nxt = px_r; py_nxt = py_r;
    ores_nxt = ores_r;

    if (ov_r && out_beat.ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt    = cmd;
          status_nxt = 1'b0;
          state_nxt  = S_EMIT;
          if ((cmd.kind inside {K_LINE, K_QUAD, K_CUBIC, K_CLOSE}) && !active_r) begin
            status_nxt = 1'b1;
          end else begin
            case (cmd.kind)
              K_MOVE: begin
                cur_x_nxt = cmd.ex; cur_y_nxt = cmd.ey;
                org_x_nxt = cmd.ex; org_y_nxt = cmd.ey;
                active_nxt = 1'b1;
              end
              K_LINE, K_QUAD, K_CUBIC: state_nxt = S_INC_START;
              K_CLOSE: begin
                if (cur_x_r != org_x_r || cur_y_r != org_y_r) seg_nxt = 1'b1;
                active_nxt = 1'b0;
              end
              K_CLEAR: begin
                cur_x_nxt = '0; cur_y_nxt = '0;
                org_x_nxt = '0; org_y_nxt = '0;
                active_nxt = 1'b0; seg_nxt = 1'b0;
                box_nxt = '0;
              end
              default: ;
            endcase
          end
        end
      end

      S_INC_START: begin
        box_nxt   = box_add(box_r, cur_x_r, cur_y_r);
        state_nxt = S_INC_END;
      end

      S_INC_END: begin
        box_nxt  = box_add(box_r, cmd_r.ex, cmd_r.ey);
        axis_nxt = 1'b0;
        state_nxt = (cmd_r.kind == K_LINE) ? S_FINISH : S_SETUP;
      end

      // Per-axis coefficients and degenerate checks
      S_SETUP: begin
        pair_nxt = 1'b0;
        rsel_nxt = 1'b0;
        state_nxt = S_NEXT;
        if (!is_cubic) begin
          if (mag(quad_d) > thr_ext) begin
            num_nxt = quad_n; den_nxt = quad_d; state_nxt = S_DIV_CHK;
          end
        end else if (ma > thr_ext) begin
          a_nxt = cub_a; b_nxt = cub_b; c_nxt = cub_c; m_nxt = mmax;
          state_nxt = S_NORM;
        end else if (mb > thr_ext) begin
          num_nxt = -cub_c; den_nxt = cub_b; state_nxt = S_DIV_CHK;
        end
      end

      // Shift coefficients together until all fit the normalized range
      S_NORM: begin
        if (m_r >= NORM_LIM) begin
          a_nxt = a_r >>> 1; b_nxt = b_r >>> 1; c_nxt = c_r >>> 1;
          m_nxt = m_r >> 1;
        end else if (a_r == '0) begin
          // leading term vanished: linear solution
          if (mb > thr_ext) begin
            num_nxt = -cub_c; den_nxt = cub_b; state_nxt = S_DIV_CHK;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          state_nxt = S_MUL1;
        end
      end

      S_MUL1: begin
        p1_nxt = $signed(b_r[NW-1:0]) * $signed(b_r[NW-1:0]);
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        p2_nxt = $signed(a_r[NW-1:0]) * $signed(c_r[NW-1:0]);
        state_nxt = S_DISC;
      end

      S_DISC: begin
        if (disc[SQ_W]) begin
          state_nxt = S_NEXT;
        end else begin
          v_nxt = disc[SQ_W-1:0];
          rt_nxt = '0;
          bit_nxt = SQ_BIT0;
          sq_cnt_nxt = '0;
          state_nxt = S_SQRT;
        end
      end

      // Floor square root, one result bit per cycle
      S_SQRT: begin
        if (v_r >= sq_sum) begin
          v_nxt  = v_r - sq_sum;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r == SQ_CNT_W'(SQ_STEPS - 1)) state_nxt = S_ROOT;
      end

      S_ROOT: begin
        num_nxt = rt_s - bn_s;
        den_nxt = an_s <<< 1;
        pair_nxt = 1'b1;
        state_nxt = S_DIV_CHK;
      end

      // Root must lie strictly inside (0,1)
      S_DIV_CHK: begin
        if (num_r == '0 || den_r == '0 || (num_r[SW-1] != den_r[SW-1]) || dn >= dd) begin
          state_nxt = S_NEXT;
        end else begin
          dd_nxt = dd[DW-1:0];
          rem_nxt = {1'b0, dn[DW-1:0]};
          t_nxt = '0;
          dv_cnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end

      // Restoring division, one bit of t per cycle
      S_DIV: begin
        if (rem2 >= {1'b0, dd_r}) begin
          rem_nxt = rem2 - {1'b0, dd_r};
          t_nxt = {t_r[TFB-2:0], 1'b1};
        end else begin
          rem_nxt = rem2;
          t_nxt = {t_r[TFB-2:0], 1'b0};
        end
        dv_cnt_nxt = dv_cnt_r + 1'b1;
        if (dv_cnt_r == DIV_CNT_W'(TFB - 1)) begin
          eaxis_nxt = 1'b0;
          state_nxt = S_EVAL_LOAD;
        end
      end

      S_EVAL_LOAD: begin
        q0_nxt = ev_s;
        q1_nxt = ev_a;
        q2_nxt = is_cubic ? ev_b : ev_e;
        q3_nxt = ev_e;
        step_nxt = '0;
        state_nxt = S_LERP_A;
      end

      S_LERP_A: begin
        lp_nxt = diff * $signed({1'b0, t_r});
        state_nxt = S_LERP_B;
      end

      S_LERP_B: begin
        case (idx)
          2'd1:    q1_nxt = lres;
          2'd2:    q2_nxt = lres;
          default: q0_nxt = lres;
        endcase
        step_nxt = step_r + 1'b1;
        state_nxt = S_LERP_A;
        if (last_step) begin
          if (!eaxis_r) begin
            px_nxt = lres;
            eaxis_nxt = 1'b1;
            state_nxt = S_EVAL_LOAD;
          end else begin
            py_nxt = lres;
            state_nxt = S_INC_ROOT;
          end
        end
      end

      S_INC_ROOT: begin
        box_nxt = box_add(box_r, px_r, py_r);
        state_nxt = S_NEXT;
      end

      // Second root, next axis or done
      S_NEXT: begin
        if (pair_r && !rsel_r && rt_r != '0) begin
          rsel_nxt = 1'b1;
          num_nxt = -bn_s - rt_s;
          den_nxt = an_s <<< 1;
          state_nxt = S_DIV_CHK;
        end else if (!axis_r) begin
          axis_nxt = 1'b1;
          state_nxt = S_SETUP;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        cur_x_nxt = cmd_r.ex;
        cur_y_nxt = cmd_r.ey;
        seg_nxt = 1'b1;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!ov_r || out_beat.ready) begin
          ov_nxt = 1'b1;
          ores_nxt = '{box: box_r, nonempty: seg_r, status: status_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      org_x_r  <= '0;
      org_y_r  <= '0;
      active_r <= 1'b0;
      seg_r    <= 1'b0;
      box_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      org_x_r  <= org_x_nxt;
      org_y_r  <= org_y_nxt;
      active_r <= active_nxt;
      seg_r    <= seg_nxt;
      box_r    <= box_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    axis_r   <= axis_nxt;
    eaxis_r  <= eaxis_nxt;
    pair_r   <= pair_nxt;
    rsel_r   <= rsel_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; m_r <= m_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt;
    v_r <= v_nxt; rt_r <= rt_nxt; bit_r <= bit_nxt; sq_cnt_r <= sq_cnt_nxt;
    num_r <= num_nxt; den_r <= den_nxt;
    dd_r <= dd_nxt; rem_r <= rem_nxt; t_r <= t_nxt; dv_cnt_r <= dv_cnt_nxt;
    step_r <= step_nxt;
    q0_r <= q0_nxt; q1_r <= q1_nxt; q2_r <= q2_nxt; q3_r <= q3_nxt;
    lp_r <= lp_nxt;
    px_r <= px_nxt; py_r <= py_nxt;
    ores_r <= ores_nxt;
  end

  // Result beat
  assign out_beat.valid         = ov_r;
  assign out_beat.min_x         = ores_r.box.lo_x;
  assign out_beat.min_y         = ores_r.box.lo_y;
  assign out_beat.max_x         = ores_r.box.hi_x;
  assign out_beat.max_y         = ores_r.box.hi_y;
  assign out_beat.bounds_valid  = ores_r.box.known;
  assign out_beat.path_nonempty = ores_r.nonempty;
  assign out_beat.status        = ores_r.status;

endmodule

[rtl/path_tight_bounds_tracker_core.sv]
// Timing: move, close, reset and rejected commands reach the result beat without the
// solver; a line only adds its box updates. Quadratic time is set by the restoring t
// divider and the single shared interpolation multiplier; a cubic also uses the
// one-bit-per-cycle square root.
// Throughput: one command at a time in the solver; a queue takes new beats meanwhile, while not full.
// Reset (rst_n low, synchronous) clears path state, box, queue and threshold.
module path_tight_bounds_tracker_core import ptbt_pkg::*; #(
  parameter int QUEUE_DEPTH = 2   // power of two, at least 2
) (
  input  logic             clk,
  input  logic             rst_n,
  ptbt_in_if.sink          in_beat,
  ptbt_out_if.source       out_beat,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  logic [THR_W-1:0] thr_r, thr_nxt;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;

  // Degenerate threshold register
  assign thr_nxt = cfg_we ? cfg_wdata : thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= '0;
    else        thr_r <= thr_nxt;
  end

  ptbt_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  ptbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .thr       (thr_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_beat  (out_beat)
  );

endmodule
